// File: design/frame_syntax_checker_assert.svh
// assertion macros for the frame syntax checker
`ifndef FRAME_SYNTAX_CHECKER_ASSERT_SVH
`define FRAME_SYNTAX_CHECKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FSC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/fsc_pkg.sv
// types and constants for the frame syntax checker
`timescale 1ns / 1ps

package fsc_pkg;

    localparam int COUNT_W = 17;
    localparam int TOTAL_W = COUNT_W + 1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0] FRAME_OVERHEAD = TOTAL_W'(9);

    localparam logic [7:0] MAGIC_BYTES [4] = '{8'h43, 8'h49, 8'h55, 8'h50};

    localparam logic [COUNT_W-1:0] POS_TYPE   = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] POS_LEN_HI = COUNT_W'(5);
    localparam logic [COUNT_W-1:0] POS_LEN_LO = COUNT_W'(6);
    localparam logic [COUNT_W-1:0] POS_SUM_START = COUNT_W'(2);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SIZE     = 2'd1,
        ST_MAGIC    = 2'd2,
        ST_CHECKSUM = 2'd3
    } status_t;

endpackage

// File: design/frame_syntax_checker.sv
// Frame syntax checker: takes one byte per beat of a frame made of the magic
// bytes C I U P, a type byte, a big-endian 16-bit payload length, the payload,
// an 8-bit additive checksum and its complement (0xFF minus the sum). On the
// beat marked last_byte it gives one status (ok, size, magic or checksum
// error, in that priority) with the captured type and length; a message
// shorter than 9 bytes or whose count is not length plus 9 is a size error.
// Sustained rate is one byte per cycle while no last byte waits. Each byte is
// registered on input and from there updates the frame state; a last byte
// instead loads the status register, from which its status is offered. Input
// stalls only while a last byte waits for the single status register to be
// emptied.
`timescale 1ns / 1ps

`include "frame_syntax_checker_assert.svh"

module frame_syntax_checker
    import fsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        status_valid,
    input  logic        status_stall,
    output logic [1:0]  status_code,
    output logic [7:0]  message_type,
    output logic [15:0] payload_length
);

    // input register
    logic        a_valid_reg, a_valid_next;
    logic [7:0]  a_data_reg;
    logic        a_last_reg;

    // frame state
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  newest_reg, newest_next;
    logic [7:0]  older_reg, older_next;
    logic        magic_good_reg, magic_good_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] length_reg, length_next;

    // status register
    logic        status_valid_reg, status_valid_next;
    status_t     status_code_reg, status_code_next;
    logic [7:0]  message_type_reg, message_type_next;
    logic [15:0] payload_length_reg, payload_length_next;

    logic               out_free;
    logic               a_fire;
    logic               byte_take;
    logic [7:0]         checksum;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] expected;
    logic               magic_hit;
    logic [7:0]         type_cap;
    logic [15:0]        length_cap;
    logic               magic_cap;
    status_t            status_calc;

    assign out_free   = !status_valid_reg || !status_stall;
    // only a last beat needs room in the status register
    assign a_fire     = a_valid_reg && (!a_last_reg || out_free);
    assign byte_stall = a_valid_reg && !a_fire;
    assign byte_take  = byte_valid && !byte_stall;

    // header capture from the beat now in the input register
    always_comb
    begin
        magic_hit  = (a_data_reg == MAGIC_BYTES[count_reg[1:0]]);
        magic_cap  = magic_good_reg;
        type_cap   = type_reg;
        length_cap = length_reg;
        if (count_reg < POS_TYPE)
        begin
            if (!magic_hit)
                magic_cap = 1'b0;
        end
        else if (count_reg == POS_TYPE)
            type_cap = a_data_reg;
        else if (count_reg == POS_LEN_HI)
            length_cap = {a_data_reg, length_reg[7:0]};
        else if (count_reg == POS_LEN_LO)
            length_cap = {length_reg[15:8], a_data_reg};
    end

    always_comb
    begin
        checksum = sum_reg + older_reg;
        total    = {1'b0, count_reg} + TOTAL_W'(1);
        expected = {{(TOTAL_W-16){1'b0}}, length_cap} + FRAME_OVERHEAD;
        priority if (total < FRAME_OVERHEAD || total != expected)
            status_calc = ST_SIZE;
        else if (!magic_cap)
            status_calc = ST_MAGIC;
        else if (checksum != newest_reg)
            status_calc = ST_CHECKSUM;
        else if ((8'hFF - checksum) != a_data_reg)
            status_calc = ST_CHECKSUM;
        else
            status_calc = ST_OK;
    end

    always_comb
    begin
        a_valid_next        = byte_take || (a_valid_reg && !a_fire);
        count_next          = count_reg;
        sum_next            = sum_reg;
        newest_next         = newest_reg;
        older_next          = older_reg;
        magic_good_next     = magic_good_reg;
        type_next           = type_reg;
        length_next         = length_reg;
        status_valid_next   = status_valid_reg && status_stall;
        status_code_next    = status_code_reg;
        message_type_next   = message_type_reg;
        payload_length_next = payload_length_reg;
        if (a_fire)
        begin
            if (a_last_reg)
            begin
                status_valid_next   = 1'b1;
                status_code_next    = status_calc;
                message_type_next   = type_cap;
                payload_length_next = length_cap;
                // back to the start of a frame
                count_next      = '0;
                sum_next        = '0;
                newest_next     = '0;
                older_next      = '0;
                magic_good_next = 1'b1;
                type_next       = '0;
                length_next     = '0;
            end
            else
            begin
                if (count_reg >= POS_SUM_START)
                    sum_next = checksum;
                older_next      = newest_reg;
                newest_next     = a_data_reg;
                magic_good_next = magic_cap;
                type_next       = type_cap;
                length_next     = length_cap;
                if (count_reg != COUNT_MAX)
                    count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg      <= 1'b0;
            count_reg        <= '0;
            sum_reg          <= '0;
            newest_reg       <= '0;
            older_reg        <= '0;
            magic_good_reg   <= 1'b1;
            type_reg         <= '0;
            length_reg       <= '0;
            status_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg      <= a_valid_next;
            count_reg        <= count_next;
            sum_reg          <= sum_next;
            newest_reg       <= newest_next;
            older_reg        <= older_next;
            magic_good_reg   <= magic_good_next;
            type_reg         <= type_next;
            length_reg       <= length_next;
            status_valid_reg <= status_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_take)
        begin
            a_data_reg <= data_byte;
            a_last_reg <= last_byte;
        end
        status_code_reg    <= status_code_next;
        message_type_reg   <= message_type_next;
        payload_length_reg <= payload_length_next;
    end

    assign status_valid   = status_valid_reg;
    assign status_code    = status_code_reg;
    assign message_type   = message_type_reg;
    assign payload_length = payload_length_reg;

    `FSC_ASSERT_SAME(a_stall_only_on_last, byte_stall, a_valid_reg && a_last_reg, "stall without a waiting last beat")
    `FSC_ASSERT_NEXT(a_last_gives_status, a_fire && a_last_reg, status_valid_reg, "last beat gave no status")
    `FSC_ASSERT_NEXT(a_last_clears_state, a_fire && a_last_reg, count_reg == '0 && magic_good_reg, "frame state not cleared after last beat")

endmodule

// File: sim/testbench.sv
// self-checking testbench for the frame syntax checker
`timescale 1ns / 1ps

module testbench;
    import fsc_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_BYTES = 1950;

    typedef struct {
        status_t     code;
        logic [7:0]  mtype;
        logic [15:0] plen;
    } frame_status_t;

    typedef enum {
        FK_GOOD,
        FK_MAGIC,
        FK_SUM,
        FK_COMPL,
        FK_LENGTH,
        FK_TRUNC,
        FK_EXTRA,
        FK_NOISE
    } frame_kind_t;

    class status_scoreboard;
        logic [COUNT_W-1:0] byte_count;
        logic [7:0]         running_sum;
        logic [7:0]         delay_newest;
        logic [7:0]         delay_older;
        logic               magic_good;
        logic [7:0]         type_hold;
        logic [15:0]        length_hold;
        frame_status_t      expected_q[$];
        int                 fails;

        function new();
            fails = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_count   = '0;
            running_sum  = '0;
            delay_newest = '0;
            delay_older  = '0;
            magic_good   = 1'b1;
            type_hold    = '0;
            length_hold  = '0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            fails++;
        endtask

        // predict the status of the frame that this beat belongs to
        function void note_byte(logic [7:0] b, logic last);
            logic [TOTAL_W-1:0] total;
            logic [7:0]         sum;
            frame_status_t      st;
            if (byte_count < POS_TYPE)
            begin
                if (b != MAGIC_BYTES[byte_count[1:0]])
                    magic_good = 1'b0;
            end
            else if (byte_count == POS_TYPE)
                type_hold = b;
            else if (byte_count == POS_LEN_HI)
                length_hold[15:8] = b;
            else if (byte_count == POS_LEN_LO)
                length_hold[7:0] = b;

            if (last)
            begin
                total = {1'b0, byte_count} + TOTAL_W'(1);
                sum = running_sum + delay_older;
                if (total < FRAME_OVERHEAD ||
                    total != {2'b00, length_hold} + FRAME_OVERHEAD)
                    st.code = ST_SIZE;
                else if (!magic_good)
                    st.code = ST_MAGIC;
                else if (sum != delay_newest)
                    st.code = ST_CHECKSUM;
                else if (8'(8'hFF - sum) != b)
                    st.code = ST_CHECKSUM;
                else
                    st.code = ST_OK;
                st.mtype = type_hold;
                st.plen = length_hold;
                expected_q.push_back(st);
                clear_frame();
            end
            else
            begin
                if (byte_count >= POS_SUM_START)
                    running_sum = running_sum + delay_older;
                delay_older = delay_newest;
                delay_newest = b;
                if (byte_count != COUNT_MAX)
                    byte_count = byte_count + 1'b1;
            end
        endfunction

        task check_status(logic [1:0] code, logic [7:0] mtype, logic [15:0] plen);
            frame_status_t exp;
            if (expected_q.size() == 0)
                report("status beat with no frame outstanding");
            else
            begin
                exp = expected_q.pop_front();
                if (code !== exp.code)
                    report($sformatf("status_code %0d, predicted %0d", code, exp.code));
                if (mtype !== exp.mtype)
                    report($sformatf("message_type %h, predicted %h", mtype, exp.mtype));
                if (plen !== exp.plen)
                    report($sformatf("payload_length %h, predicted %h", plen, exp.plen));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        status_valid;
    logic        status_stall = 1'b0;
    logic [1:0]  status_code;
    logic [7:0]  message_type;
    logic [15:0] payload_length;

    status_scoreboard sb;
    logic [7:0] frame_buf[$];
    int         burst_left = 0;
    bit         sender_eager = 1'b0;
    bit         hold_req = 1'b0;
    int         bytes_sent = 0;

    frame_syntax_checker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .status_valid   (status_valid),
        .status_stall   (status_stall),
        .status_code    (status_code),
        .message_type   (message_type),
        .payload_length (payload_length)
    );

    always #6 clk = ~clk;

    // valid stays up after the beat; the caller decides on a gap
    task send_byte(logic [7:0] b, logic last);
        byte_valid <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
    endtask

    // build one message of the given kind and send it; for noise, len is the byte count
    task send_frame(frame_kind_t kind, logic [7:0] mtype, int len);
        logic [7:0]  sum;
        logic [15:0] len16;
        int          i;
        int          gap;
        frame_buf.delete();
        len16 = len[15:0];
        if (kind == FK_NOISE)
        begin
            repeat (len)
                frame_buf.push_back(8'($urandom));
        end
        else
        begin
            for (i = 0; i < 4; i++)
                frame_buf.push_back(MAGIC_BYTES[i]);
            frame_buf.push_back(mtype);
            frame_buf.push_back(len16[15:8]);
            frame_buf.push_back(len16[7:0]);
            repeat (len)
                frame_buf.push_back(8'($urandom));
            sum = 8'h00;
            foreach (frame_buf[k])
                sum = sum + frame_buf[k];
            frame_buf.push_back(sum);
            frame_buf.push_back(8'(8'hFF - sum));
            case (kind)
                FK_MAGIC:
                    frame_buf[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
                FK_SUM:
                    frame_buf[frame_buf.size() - 2] ^= 8'($urandom_range(1, 255));
                FK_COMPL:
                    frame_buf[frame_buf.size() - 1] ^= 8'($urandom_range(1, 255));
                FK_LENGTH:
                    frame_buf[$urandom_range(5, 6)] ^= 8'($urandom_range(1, 255));
                FK_TRUNC:
                    repeat ($urandom_range(1, frame_buf.size() - 1))
                        void'(frame_buf.pop_back());
                FK_EXTRA:
                    repeat ($urandom_range(1, 4))
                        frame_buf.push_back(8'($urandom));
                default: ;
            endcase
        end

        for (i = 0; i < frame_buf.size(); i++)
        begin
            if (burst_left == 0 && !sender_eager)
            begin
                gap = $urandom_range(0, 8);
                if (gap > 0)
                begin
                    byte_valid <= 1'b0;
                    repeat (gap)
                        @(posedge clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
            if (burst_left > 0)
                burst_left--;
        end
        bytes_sent += frame_buf.size();
    endtask

    // accepted beats on both sides, sampled at the edge that takes them
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (status_valid && !status_stall)
                sb.check_status(status_code, message_type, payload_length);
            if (byte_valid && !byte_stall)
                sb.note_byte(data_byte, last_byte);
        end
    end

    // receiver: stall patterns that change every so often, plus a long hold on request
    initial
    begin : receiver
        int mode;
        int left;
        int phase;
        mode = 0;
        left = 0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                status_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 200);
                end
                left--;
                phase = (phase + 1) % 5;
                case (mode)
                    0: status_stall <= 1'b0;
                    1: status_stall <= 1'($urandom_range(0, 1));
                    2: status_stall <= ($urandom_range(0, 3) != 0);
                    default: status_stall <= (phase < 2);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((byte_valid && !byte_stall) || (status_valid && !status_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int r;
        int len;
        frame_kind_t kind;
        sb = new();
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_frame(FK_GOOD, 8'h00, 0);
        send_frame(FK_GOOD, 8'hFF, 3);
        send_frame(FK_NOISE, 8'h00, 1);
        send_frame(FK_NOISE, 8'h00, 8);
        send_frame(FK_LENGTH, 8'h5A, 0);
        send_frame(FK_MAGIC, 8'h11, 2);
        send_frame(FK_SUM, 8'h22, 4);
        send_frame(FK_COMPL, 8'h33, 1);
        send_frame(FK_EXTRA, 8'h44, 2);
        send_frame(FK_TRUNC, 8'h55, 6);
        send_frame(FK_GOOD, 8'hA5, 300);
        send_frame(FK_GOOD, 8'h3C, 5);

        hold_req = 1'b1;
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (bytes_sent > RANDOM_BYTES / 2 && bytes_sent < RANDOM_BYTES / 2 + 20)
                hold_req = 1'b1;
            sender_eager = ($urandom_range(0, 3) == 0);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 300)
                                              : $urandom_range(0, 16);
            r = $urandom_range(0, 99);
            if (r < 50)
                kind = FK_GOOD;
            else if (r < 58)
                kind = FK_MAGIC;
            else if (r < 66)
                kind = FK_SUM;
            else if (r < 74)
                kind = FK_COMPL;
            else if (r < 82)
                kind = FK_LENGTH;
            else if (r < 88)
                kind = FK_TRUNC;
            else if (r < 94)
                kind = FK_EXTRA;
            else
            begin
                kind = FK_NOISE;
                len = $urandom_range(1, 14);
            end
            send_frame(kind, 8'($urandom), len);
        end
        byte_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (sb.fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
